### rtl/pm_air_quality_index_defines.svh
// Assertion macros for the particulate air quality index block.
// Used by the checker; expects i_clk and i_rst_n in the enclosing scope.
`ifndef PM_AIR_QUALITY_INDEX_DEFINES_SVH
`define PM_AIR_QUALITY_INDEX_DEFINES_SVH

// same-cycle implication
`define AQI_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("aqi assertion failed");

// next-cycle implication
`define AQI_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("aqi assertion failed");

`endif

### rtl/pm_aqi_pkg.sv
// Shared types, constants and breakpoint tables for the air quality index block.
// No dependencies.
package pm_aqi_pkg;

    localparam int SEGMENTS     = 7;
    localparam int SEG_W        = 3;
    localparam int PM_W         = 16;
    localparam int CONC_W       = 20;
    localparam int OFF_W        = 11;
    localparam int DIFF_W       = 14;
    localparam int NUM_W        = 24;
    localparam int RECIP_W      = 19;
    localparam int RECIP_SHIFT  = 24;
    localparam int PROD_W       = NUM_W + RECIP_W;
    localparam int Q_W          = 14;
    localparam int SPAN_W       = 11;
    localparam int AQI_W        = 16;
    localparam int CAT_W        = 3;
    localparam int LED_W        = 8;
    localparam int LANE_STAGES  = 5;
    localparam int PIPE_STAGES  = LANE_STAGES + 1;

    localparam int ADDR_W       = 3;
    localparam int DATA_W       = 32;
    localparam logic REG_DISPLAY_ENABLE = 1'b0;
    localparam logic DISPLAY_ENABLE_RST = 1'b1;

    localparam logic [SEG_W-1:0] SEG_ABOVE = 3'd7;

    localparam logic [CAT_W-1:0] CAT_GOOD           = 3'd0;
    localparam logic [CAT_W-1:0] CAT_MODERATE       = 3'd1;
    localparam logic [CAT_W-1:0] CAT_SENSITIVE      = 3'd2;
    localparam logic [CAT_W-1:0] CAT_UNHEALTHY      = 3'd3;
    localparam logic [CAT_W-1:0] CAT_VERY_UNHEALTHY = 3'd4;
    localparam logic [CAT_W-1:0] CAT_HAZARDOUS      = 3'd5;

    localparam logic [AQI_W-1:0] AQI_MAX = 16'd50000;

    typedef enum logic {
        TAB_PM25,
        TAB_PM10
    } t_tab;

    typedef struct packed {
        logic [LANE_STAGES-1:0] load;
    } t_lane_ctl;

    typedef struct packed {
        logic [AQI_W-1:0] sub;
        logic [SEG_W-1:0] seg;
    } t_lane_res;

    typedef struct packed {
        logic [LED_W-1:0] red;
        logic [LED_W-1:0] green;
        logic [LED_W-1:0] blue;
    } t_rgb;

    // PM2.5 bounds in tenths of ug/m3, PM10 in whole ug/m3
    function automatic logic [CONC_W-1:0] f_seg_hi(t_tab tab, logic [SEG_W-1:0] seg);
        case (seg)
            3'd0:    f_seg_hi = (tab == TAB_PM25) ? 20'd120  : 20'd54;
            3'd1:    f_seg_hi = (tab == TAB_PM25) ? 20'd354  : 20'd154;
            3'd2:    f_seg_hi = (tab == TAB_PM25) ? 20'd554  : 20'd254;
            3'd3:    f_seg_hi = (tab == TAB_PM25) ? 20'd1504 : 20'd354;
            3'd4:    f_seg_hi = (tab == TAB_PM25) ? 20'd2504 : 20'd424;
            3'd5:    f_seg_hi = (tab == TAB_PM25) ? 20'd3504 : 20'd504;
            3'd6:    f_seg_hi = (tab == TAB_PM25) ? 20'd5004 : 20'd604;
            default: f_seg_hi = '1;
        endcase
    endfunction

    function automatic logic [CONC_W-1:0] f_seg_lo(t_tab tab, logic [SEG_W-1:0] seg);
        case (seg)
            3'd0:    f_seg_lo = 20'd0;
            3'd1:    f_seg_lo = (tab == TAB_PM25) ? 20'd121  : 20'd55;
            3'd2:    f_seg_lo = (tab == TAB_PM25) ? 20'd355  : 20'd155;
            3'd3:    f_seg_lo = (tab == TAB_PM25) ? 20'd555  : 20'd255;
            3'd4:    f_seg_lo = (tab == TAB_PM25) ? 20'd1505 : 20'd355;
            3'd5:    f_seg_lo = (tab == TAB_PM25) ? 20'd2505 : 20'd425;
            3'd6:    f_seg_lo = (tab == TAB_PM25) ? 20'd3505 : 20'd505;
            default: f_seg_lo = 20'd0;
        endcase
    endfunction

    function automatic logic [SPAN_W-1:0] f_span(t_tab tab, logic [SEG_W-1:0] seg);
        case (seg)
            3'd0:    f_span = (tab == TAB_PM25) ? 11'd120  : 11'd54;
            3'd1:    f_span = (tab == TAB_PM25) ? 11'd233  : 11'd99;
            3'd2:    f_span = (tab == TAB_PM25) ? 11'd199  : 11'd99;
            3'd3:    f_span = (tab == TAB_PM25) ? 11'd949  : 11'd99;
            3'd4:    f_span = (tab == TAB_PM25) ? 11'd999  : 11'd69;
            3'd5:    f_span = (tab == TAB_PM25) ? 11'd999  : 11'd79;
            3'd6:    f_span = (tab == TAB_PM25) ? 11'd1499 : 11'd99;
            default: f_span = 11'd1;
        endcase
    endfunction

    // floor(2^24 / span)
    function automatic logic [RECIP_W-1:0] f_recip(t_tab tab, logic [SEG_W-1:0] seg);
        case (seg)
            3'd0:    f_recip = (tab == TAB_PM25) ? 19'd139810 : 19'd310689;
            3'd1:    f_recip = (tab == TAB_PM25) ? 19'd72005  : 19'd169466;
            3'd2:    f_recip = (tab == TAB_PM25) ? 19'd84307  : 19'd169466;
            3'd3:    f_recip = (tab == TAB_PM25) ? 19'd17678  : 19'd169466;
            3'd4:    f_recip = (tab == TAB_PM25) ? 19'd16794  : 19'd243148;
            3'd5:    f_recip = (tab == TAB_PM25) ? 19'd16794  : 19'd212369;
            3'd6:    f_recip = (tab == TAB_PM25) ? 19'd11192  : 19'd169466;
            default: f_recip = 19'd0;
        endcase
    endfunction

    // index span of the segment times 100
    function automatic logic [DIFF_W-1:0] f_diff100(logic [SEG_W-1:0] seg);
        case (seg)
            3'd0:    f_diff100 = 14'd5000;
            3'd1:    f_diff100 = 14'd4900;
            3'd2:    f_diff100 = 14'd4900;
            3'd3:    f_diff100 = 14'd4900;
            3'd4:    f_diff100 = 14'd9900;
            3'd5:    f_diff100 = 14'd9900;
            3'd6:    f_diff100 = 14'd9900;
            default: f_diff100 = 14'd0;
        endcase
    endfunction

    function automatic logic [AQI_W-1:0] f_base(logic [SEG_W-1:0] seg);
        case (seg)
            3'd0:    f_base = 16'd0;
            3'd1:    f_base = 16'd5100;
            3'd2:    f_base = 16'd10100;
            3'd3:    f_base = 16'd15100;
            3'd4:    f_base = 16'd20100;
            3'd5:    f_base = 16'd30100;
            3'd6:    f_base = 16'd40100;
            default: f_base = AQI_MAX;
        endcase
    endfunction

    function automatic t_rgb f_colour(logic [CAT_W-1:0] cat);
        case (cat)
            CAT_GOOD:      f_colour = '{red: 8'd0,   green: 8'd255, blue: 8'd0};
            CAT_MODERATE:  f_colour = '{red: 8'd120, green: 8'd255, blue: 8'd0};
            CAT_SENSITIVE: f_colour = '{red: 8'd255, green: 8'd120, blue: 8'd0};
            CAT_UNHEALTHY: f_colour = '{red: 8'd255, green: 8'd0,   blue: 8'd0};
            default:       f_colour = '{red: 8'd180, green: 8'd0,   blue: 8'd255};
        endcase
    endfunction

endpackage

### rtl/pm_aqi_lane.sv
// One sub-index lane: segment search, interpolation and reciprocal division.
// Depends on pm_aqi_pkg.
module pm_aqi_lane
    import pm_aqi_pkg::*;
(
    input  logic              i_clk,
    input  t_tab              i_tab,
    input  t_lane_ctl         i_ctl,
    input  logic [CONC_W-1:0] i_conc,
    output t_lane_res         o_res
);

    logic [SEG_W-1:0]          r_seg1, r_seg2, r_seg3, r_seg4, r_seg5;
    logic [OFF_W-1:0]          r_off1;
    logic [NUM_W-1:0]          r_num2, r_num3, r_num4;
    logic [PROD_W-1:0]         r_prod3;
    logic [Q_W-1:0]            r_q4;
    logic [NUM_W-1:0]          r_qspan4;
    logic [AQI_W-1:0]          r_sub5;

    logic [SEG_W-1:0]          n_seg1;
    logic [CONC_W-1:0]         n_delta1;
    logic [OFF_W+DIFF_W-1:0]   n_num2;
    logic [PROD_W-1:0]         n_prod3;
    logic [Q_W-1:0]            n_q4;
    logic [Q_W+SPAN_W-1:0]     n_qspan4;
    logic [NUM_W-1:0]          n_rem5;
    logic                      n_carry5;
    logic [AQI_W-1:0]          n_sub5;

    // first segment whose upper bound holds the reading
    always_comb begin
        n_seg1 = SEG_ABOVE;
        for (int i = SEGMENTS - 1; i >= 0; i--) begin
            if (i_conc <= f_seg_hi(i_tab, SEG_W'(i))) begin
                n_seg1 = SEG_W'(i);
            end
        end
        n_delta1 = i_conc - f_seg_lo(i_tab, n_seg1);
    end

    assign n_num2   = r_off1 * f_diff100(r_seg1);
    assign n_prod3  = r_num2 * f_recip(i_tab, r_seg2);
    assign n_q4     = r_prod3[RECIP_SHIFT +: Q_W];
    assign n_qspan4 = n_q4 * f_span(i_tab, r_seg3);

    // estimate is short by at most one
    always_comb begin
        n_rem5   = r_num4 - r_qspan4;
        n_carry5 = (n_rem5 >= {{(NUM_W-SPAN_W){1'b0}}, f_span(i_tab, r_seg4)});
        n_sub5   = f_base(r_seg4) + {{(AQI_W-Q_W){1'b0}}, r_q4}
                   + {{(AQI_W-1){1'b0}}, n_carry5};
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[0]) begin
            r_seg1 <= n_seg1;
            r_off1 <= n_delta1[OFF_W-1:0];
        end
        if (i_ctl.load[1]) begin
            r_seg2 <= r_seg1;
            r_num2 <= n_num2[NUM_W-1:0];
        end
        if (i_ctl.load[2]) begin
            r_seg3  <= r_seg2;
            r_num3  <= r_num2;
            r_prod3 <= n_prod3;
        end
        if (i_ctl.load[3]) begin
            r_seg4   <= r_seg3;
            r_num4   <= r_num3;
            r_q4     <= n_q4;
            r_qspan4 <= n_qspan4[NUM_W-1:0];
        end
        if (i_ctl.load[4]) begin
            r_seg5 <= r_seg4;
            r_sub5 <= n_sub5;
        end
    end

    assign o_res = '{sub: r_sub5, seg: r_seg5};

endmodule

### rtl/pm_aqi_merge.sv
// Merging stage: worse sub-index, category and indicator colour, registered.
// Depends on pm_aqi_pkg.
module pm_aqi_merge
    import pm_aqi_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_load,
    input  logic             i_display_enable,
    input  t_lane_res        i_pm25,
    input  t_lane_res        i_pm10,
    output logic [AQI_W-1:0] o_aqi,
    output logic [CAT_W-1:0] o_cat,
    output t_rgb             o_rgb
);

    logic [AQI_W-1:0] r_aqi;
    logic [CAT_W-1:0] r_cat;
    t_rgb             r_rgb;

    logic [AQI_W-1:0] n_aqi;
    logic [SEG_W-1:0] n_seg;
    logic [CAT_W-1:0] n_cat;
    t_rgb             n_rgb;

    always_comb begin
        n_aqi = (i_pm25.sub > i_pm10.sub) ? i_pm25.sub : i_pm10.sub;
        n_seg = (i_pm25.seg > i_pm10.seg) ? i_pm25.seg : i_pm10.seg;
        n_cat = (n_seg > SEG_W'(CAT_HAZARDOUS)) ? CAT_HAZARDOUS : CAT_W'(n_seg);
        n_rgb = i_display_enable ? f_colour(n_cat) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_aqi <= n_aqi;
            r_cat <= n_cat;
            r_rgb <= n_rgb;
        end
    end

    assign o_aqi = r_aqi;
    assign o_cat = r_cat;
    assign o_rgb = r_rgb;

endmodule

### rtl/pm_air_quality_index.sv
// One transaction per cycle sustained while i_ready is high; a low i_ready with o_valid set stalls the output.
// Six pipeline stages with per-stage valid bits, the stages of each lane followed by the merging
// stage; a stalled output holds only the stages behind it that are occupied.
// Reset (i_rst_n low, synchronous): pipeline emptied, display_enable set to 1.
// Depends on pm_aqi_pkg, pm_aqi_lane and pm_aqi_merge.
module pm_air_quality_index
    import pm_aqi_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [PM_W-1:0]   i_pm25_conc,
    input  logic [PM_W-1:0]   i_pm10_conc,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [AQI_W-1:0]  o_aqi_hundredths,
    output logic [CAT_W-1:0]  o_aqi_category,
    output logic [LED_W-1:0]  o_led_red,
    output logic [LED_W-1:0]  o_led_green,
    output logic [LED_W-1:0]  o_led_blue
);

    logic                   r_display_enable;
    logic [PIPE_STAGES-1:0] r_vld;
    logic [PIPE_STAGES-1:0] n_vld;
    logic [PIPE_STAGES-1:0] load;
    logic                   cfg_wr;
    logic [CONC_W-1:0]      conc25;
    logic [CONC_W-1:0]      conc10;
    t_lane_ctl              lane_ctl;
    t_lane_res              res25;
    t_lane_res              res10;
    t_rgb                   rgb;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[ADDR_W-1] == REG_DISPLAY_ENABLE);
    assign prdata = (paddr[ADDR_W-1] == REG_DISPLAY_ENABLE)
                    ? {{(DATA_W-1){1'b0}}, r_display_enable} : '0;

    // a stage loads when empty or when its contents move on
    always_comb begin
        load[PIPE_STAGES-1] = !r_vld[PIPE_STAGES-1] || i_ready;
        for (int k = PIPE_STAGES - 2; k >= 0; k--) begin
            load[k] = !r_vld[k] || load[k+1];
        end
        n_vld[0] = load[0] ? i_valid : r_vld[0];
        for (int k = 1; k < PIPE_STAGES; k++) begin
            n_vld[k] = load[k] ? r_vld[k-1] : r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld            <= '0;
            r_display_enable <= DISPLAY_ENABLE_RST;
        end else begin
            r_vld <= n_vld;
            if (cfg_wr) begin
                r_display_enable <= pwdata[0];
            end
        end
    end

    assign o_ready       = load[0];
    assign o_valid       = r_vld[PIPE_STAGES-1];
    assign lane_ctl.load = load[LANE_STAGES-1:0];

    // PM2.5 scaled to tenths
    assign conc25 = CONC_W'({i_pm25_conc, 3'b000}) + CONC_W'({i_pm25_conc, 1'b0});
    assign conc10 = CONC_W'(i_pm10_conc);

    pm_aqi_lane u_lane_pm25 (
        .i_clk  (i_clk),
        .i_tab  (TAB_PM25),
        .i_ctl  (lane_ctl),
        .i_conc (conc25),
        .o_res  (res25)
    );

    pm_aqi_lane u_lane_pm10 (
        .i_clk  (i_clk),
        .i_tab  (TAB_PM10),
        .i_ctl  (lane_ctl),
        .i_conc (conc10),
        .o_res  (res10)
    );

    pm_aqi_merge u_merge (
        .i_clk            (i_clk),
        .i_load           (load[PIPE_STAGES-1]),
        .i_display_enable (r_display_enable),
        .i_pm25           (res25),
        .i_pm10           (res10),
        .o_aqi            (o_aqi_hundredths),
        .o_cat            (o_aqi_category),
        .o_rgb            (rgb)
    );

    assign o_led_red   = rgb.red;
    assign o_led_green = rgb.green;
    assign o_led_blue  = rgb.blue;

endmodule

### rtl/pm_aqi_checker.sv
// Port-level checks on the result channel of the index block, bound to the top level.
// Depends on pm_aqi_pkg and pm_air_quality_index_defines.svh.
`include "pm_air_quality_index_defines.svh"

module pm_aqi_checker
    import pm_aqi_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic [AQI_W-1:0] i_aqi,
    input logic [CAT_W-1:0] i_cat
);

    `AQI_ASSERT_NXT(a_stall_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_aqi) && $stable(i_cat))
    `AQI_ASSERT_IMP(a_range, i_out_valid, (i_aqi <= AQI_MAX) && (i_cat <= CAT_HAZARDOUS))
    `AQI_ASSERT_IMP(a_good_low, i_out_valid && (i_cat == CAT_GOOD), i_aqi <= 16'd5000)
    `AQI_ASSERT_IMP(a_hazard_match, i_out_valid, (i_cat == CAT_HAZARDOUS) == (i_aqi >= 16'd30100))

endmodule

bind pm_air_quality_index pm_aqi_checker u_pm_aqi_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_valid),
    .i_out_ready (i_ready),
    .i_aqi       (o_aqi_hundredths),
    .i_cat       (o_aqi_category)
);
